// ===== src/iomad_pkg.sv =====
package iomad_pkg;

	localparam int unsigned RomBytesDef  = 1048576;
	localparam int unsigned VramBytesDef = 1048576;

	localparam logic [30:0] RamBytesRst  = 31'd8388608;
	localparam logic [31:0] MachineIdRst = 32'hA55A_2BAD;
	localparam logic [47:0] NetAddrRst   = 48'h0;

	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDatW = 48;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_RAM_BYTES  = 2'd0,
		CFG_MACHINE_ID = 2'd1,
		CFG_NET_ADDR   = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		TGT_RAM    = 4'd0,
		TGT_ROM    = 4'd1,
		TGT_VRAM   = 4'd2,
		TGT_VIDEO  = 4'd3,
		TGT_CLKGEN = 4'd4,
		TGT_VIA1   = 4'd5,
		TGT_VIA2   = 4'd6,
		TGT_SCC    = 4'd7,
		TGT_MEMC   = 4'd8,
		TGT_SCSI   = 4'd9,
		TGT_SDMA   = 4'd10,
		TGT_SOUND  = 4'd11,
		TGT_IOREG  = 4'd12,
		TGT_FLOPPY = 4'd13,
		TGT_IMM    = 4'd14,
		TGT_NONE   = 4'd15
	} target_t;

	typedef struct packed {
		target_t     target;
		logic [29:0] offset;
		logic [4:0]  reg_index;
		logic [1:0]  lane;
		logic        dma_timed;
		logic [7:0]  data;
		logic        overlay_cleared;
		logic        bus_error;
	} result_t;

	typedef struct packed {
		logic        func;
		logic [31:0] address;
		logic [7:0]  write_byte;
	} access_t;

	// keep only the highest set bit
	function automatic logic [30:0] top_bit(input logic [30:0] v);
		logic [30:0] r;
		r = '0;
		for (int i = 0; i < 31; i++) begin
			if (v[i]) begin
				r = 31'(1) << i;
			end
		end
		return r;
	endfunction

endpackage

// ===== src/io_and_memory_address_decoder.sv =====
// Address decoder for a byte-wide CPU bus.
// Input channel (in_valid / in_stall): one transaction per byte access,
// func (0 read, 1 write), 32-bit address and write byte.
// Output channel (out_valid / out_stall): one result per transaction:
// target, offset, reg_index, lane, dma_timed, data, overlay_cleared, bus_error.
// Configuration: cfg_we with cfg_index and cfg_data writes ram_bytes (0),
// machine_id (1) or net_address (2); write only while the block is idle.
// A transaction taken into the input register passes through the decode logic
// into the result register, which drives the outputs.
// Throughput: one transaction per cycle unless stalled (single decode stage).
// Reset: boot overlay set (ROM mirrored over low memory), registers at
// defaults, both pipeline stages empty.
// A stalled result holds; the input register still fills behind it, and
// in_stall rises only when both stages hold a transaction.
module io_and_memory_address_decoder
	import iomad_pkg::*;
#(
	parameter int unsigned ROM_BYTES  = RomBytesDef,
	parameter int unsigned VRAM_BYTES = VramBytesDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic [31:0]        address,
	input  logic [7:0]         write_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         target,
	output logic [29:0]        offset,
	output logic [4:0]         reg_index,
	output logic [1:0]         lane,
	output logic               dma_timed,
	output logic [7:0]         data,
	output logic               overlay_cleared,
	output logic               bus_error,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgDatW-1:0] cfg_data
);

	localparam logic [29:0] RomMask  = 30'(ROM_BYTES - 1);
	localparam logic [29:0] VramMask = 30'(VRAM_BYTES - 1);

	logic [30:0] ram_bytes_q;
	logic [31:0] machine_id_q;
	logic [47:0] net_addr_q;
	logic        overlay_q;

	logic        valid_s1;
	access_t     acc_s1;
	logic        valid_s2;
	result_t     res_s2;

	logic        adv_s2;
	logic        load_s1;
	result_t     res;
	logic        clr_ovl;

	assign adv_s2   = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv_s2;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_bytes_q  <= RamBytesRst;
			machine_id_q <= MachineIdRst;
			net_addr_q   <= NetAddrRst;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RAM_BYTES:  ram_bytes_q  <= top_bit(cfg_data[30:0]);
				CFG_MACHINE_ID: machine_id_q <= cfg_data[31:0];
				CFG_NET_ADDR:   net_addr_q   <= cfg_data[47:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			overlay_q <= 1'b1;
		end else begin
			if (!valid_s1 || adv_s2) begin
				valid_s1 <= load_s1;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (valid_s1 && adv_s2 && clr_ovl) begin
				overlay_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			acc_s1 <= '{func: func, address: address, write_byte: write_byte};
		end
		if (adv_s2 && valid_s1) begin
			res_s2 <= res;
		end
	end

	logic        wr;
	logic [31:0] a;
	logic [7:0]  wb;
	logic [7:0]  pass;
	logic [27:0] sub;
	logic [17:0] base;
	logic [9:0]  voff;
	logic [7:0]  chk;

	always_comb begin
		wr   = acc_s1.func;
		a    = acc_s1.address;
		wb   = acc_s1.write_byte;
		pass = wr ? wb : 8'h00;
		sub  = a[27:0];
		base = sub[17:0];
		voff = a[9:0];
		chk  = ~(net_addr_q[47:40] ^ net_addr_q[39:32] ^ net_addr_q[31:24]
			^ net_addr_q[23:16] ^ net_addr_q[15:8] ^ net_addr_q[7:0]);

		res = '{target: TGT_NONE, default: '0};
		clr_ovl = 1'b0;

		if (a[31:30] == 2'b00) begin
			if (overlay_q) begin
				if (wr) begin
					res.data = wb;
				end else begin
					res.target = TGT_ROM;
					res.offset = a[29:0] & RomMask;
				end
			end else if ({1'b0, a} < {2'b00, ram_bytes_q}) begin
				res.target = TGT_RAM;
				res.offset = a[29:0];
				res.data   = pass;
			end else if (wr) begin
				res.data = wb;
			end else begin
				res.target = TGT_IMM;
				res.data   = 8'hFF;
			end
		end else if (a[31:28] == 4'h4) begin
			if (wr) begin
				res.data = wb;
			end else begin
				res.target = TGT_ROM;
				res.offset = a[29:0] & RomMask;
				clr_ovl = overlay_q;
				res.overlay_cleared = overlay_q;
			end
		end else if (a[31:28] == 4'h5) begin
			if (sub[27:16] == 12'hFFF) begin
				if (wr) begin
					res.data = wb;
				end else begin
					res.target = TGT_IMM;
					case (sub[1:0])
						2'd0:    res.data = machine_id_q[31:24];
						2'd1:    res.data = machine_id_q[23:16];
						2'd2:    res.data = machine_id_q[15:8];
						default: res.data = machine_id_q[7:0];
					endcase
				end
			end else if (base[17:13] == 5'd0) begin
				res.target    = TGT_VIA1;
				res.reg_index = {1'b0, base[12:9]};
				res.data      = pass;
			end else if (sub[27:24] == 4'd0 && sub[19:13] == 7'd1) begin
				res.target    = TGT_VIA2;
				res.reg_index = {1'b0, sub[12:9]};
				res.data      = pass;
			end else if (!wr && base[17:3] == 15'h1000) begin
				res.target = TGT_IMM;
				case (base[2:0])
					3'd0:    res.data = net_addr_q[47:40];
					3'd1:    res.data = net_addr_q[39:32];
					3'd2:    res.data = net_addr_q[31:24];
					3'd3:    res.data = net_addr_q[23:16];
					3'd4:    res.data = net_addr_q[15:8];
					3'd5:    res.data = net_addr_q[7:0];
					3'd6:    res.data = 8'h00;
					default: res.data = chk;
				endcase
			end else if (base[17:13] == 5'd6) begin
				res.target = TGT_SCC;
				res.lane   = {base[2], base[1]};
				res.data   = pass;
			end else if (base[17:13] == 5'd7) begin
				res.target    = TGT_MEMC;
				res.reg_index = base[6:2];
				res.lane      = base[1:0];
				res.data      = pass;
			end else if (base[17:8] == 10'h100) begin
				res.target    = TGT_SCSI;
				res.reg_index = {1'b0, base[7:4]};
				res.data      = pass;
			end else if (base[17:2] == 16'h4040) begin
				res.target    = TGT_SDMA;
				res.lane      = base[1:0];
				res.dma_timed = sub[19];
				res.data      = pass;
			end else if (sub[27:24] == 4'd0 && sub[19:12] == 8'h14) begin
				res.target = TGT_SOUND;
				res.offset = {18'd0, a[11:0]};
				res.data   = pass;
			end else if (sub[27:24] == 4'd0 && sub[19:13] == 7'd12) begin
				res.target    = TGT_IOREG;
				res.reg_index = sub[12:8];
				res.lane      = {1'b0, sub[0]};
				res.data      = pass;
			end else if (sub[27:24] == 4'd0 && sub[19:13] == 7'd15) begin
				if (!wr && a[0]) begin
					res.target = TGT_IMM;
				end else begin
					res.target    = TGT_FLOPPY;
					res.reg_index = {1'b0, sub[12:9]};
					res.data      = pass;
				end
			end else begin
				res.target = wr ? TGT_NONE : TGT_IMM;
				res.data   = pass;
			end
		end else if (a[31:21] == 11'h7C8) begin
			res.target = TGT_VRAM;
			res.offset = {9'd0, a[20:0]} & VramMask;
			res.data   = pass;
		end else if (a[31:10] == 22'h3E6000) begin
			if (wr && voff[9:8] == 2'b11) begin
				res.target = TGT_CLKGEN;
				res.offset = {20'd0, voff};
				res.lane   = voff[1:0];
				res.data   = wb;
			end else if (!wr && voff[9:2] == 8'h84 && voff[1:0] != 2'b11) begin
				res.target = TGT_IMM;
			end else begin
				res.target = TGT_VIDEO;
				res.offset = {20'd0, voff};
				res.lane   = voff[1:0];
				res.data   = pass;
			end
		end else begin
			res.data      = pass;
			res.bus_error = 1'b1;
		end
	end

	assign out_valid       = valid_s2;
	assign target          = res_s2.target;
	assign offset          = res_s2.offset;
	assign reg_index       = res_s2.reg_index;
	assign lane            = res_s2.lane;
	assign dma_timed       = res_s2.dma_timed;
	assign data            = res_s2.data;
	assign overlay_cleared = res_s2.overlay_cleared;
	assign bus_error       = res_s2.bus_error;

`ifndef NO_ASSERTIONS
	a_clr_is_rom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overlay_cleared |-> target == TGT_ROM)
		else $error("overlay cleared on non-ROM result");
	a_berr_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bus_error |-> target == TGT_NONE)
		else $error("bus error with a target");
	a_ovl_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!overlay_q |=> !overlay_q)
		else $error("boot overlay set again");
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");
`endif

endmodule

// ===== bench/tb_io_and_memory_address_decoder.sv =====
module tb_io_and_memory_address_decoder
	import iomad_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ROM_SIZE    = RomBytesDef;
	localparam int unsigned VRAM_SIZE   = VramBytesDef;
	localparam int unsigned CYCLE_LIMIT = 500000;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               in_valid   = 1'b0;
	logic               in_stall;
	logic               func       = 1'b0;
	logic [31:0]        address    = '0;
	logic [7:0]         write_byte = '0;
	logic               out_valid;
	logic               out_stall  = 1'b0;
	logic [3:0]         target;
	logic [29:0]        offset;
	logic [4:0]         reg_index;
	logic [1:0]         lane;
	logic               dma_timed;
	logic [7:0]         data;
	logic               overlay_cleared;
	logic               bus_error;
	logic               cfg_we     = 1'b0;
	logic [CfgIdxW-1:0] cfg_index  = '0;
	logic [CfgDatW-1:0] cfg_data   = '0;

	// decoder state as the bench sees it
	logic        overlay_on = 1'b1;
	logic [30:0] ram_size   = RamBytesRst;
	logic [31:0] id_word    = MachineIdRst;
	logic [47:0] mac_addr   = NetAddrRst;

	result_t pending_decodes[$];
	result_t want;
	int      errors      = 0;
	int      cycle_count = 0;
	logic    tx_gaps     = 1'b1;
	logic    rx_gaps     = 1'b1;
	logic    long_hold   = 1'b0;

	io_and_memory_address_decoder dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				pending_decodes.size());
			$display("tb_io_and_memory_address_decoder: FAIL");
			$finish;
		end
	end

	function automatic result_t decode_access(input logic wr, input logic [31:0] addr,
			input logic [7:0] wb);
		result_t     r;
		logic [7:0]  pass;
		logic [31:0] sub, base, m, off;
		logic [7:0]  v;
		r = '0;
		r.target = TGT_NONE;
		pass = wr ? wb : 8'h00;
		if (addr < 32'h4000_0000) begin
			if (overlay_on) begin
				if (wr) begin
					r.data = wb;
				end else begin
					r.target = TGT_ROM;
					r.offset = 30'(addr & (ROM_SIZE - 1));
				end
			end else if (addr < 32'(ram_size)) begin
				r.target = TGT_RAM;
				r.offset = addr[29:0];
				r.data = pass;
			end else if (wr) begin
				r.data = wb;
			end else begin
				r.target = TGT_IMM;
				r.data = 8'hFF;
			end
		end else if (addr < 32'h5000_0000) begin
			if (wr) begin
				r.data = wb;
			end else begin
				if (overlay_on) begin
					overlay_on = 1'b0;
					r.overlay_cleared = 1'b1;
				end
				r.target = TGT_ROM;
				r.offset = 30'(addr & (ROM_SIZE - 1));
			end
		end else if (addr < 32'h6000_0000) begin
			sub = addr & 32'h0FFF_FFFF;
			base = sub & 32'h0003_FFFF;
			m = sub & ~32'h00F0_0000;
			r.data = pass;
			if (sub >= 32'h0FFF_0000) begin
				if (!wr) begin
					r.target = TGT_IMM;
					r.data = 8'(id_word >> (8 * (3 - sub[1:0])));
				end
			end else if (base < 32'h2000) begin
				r.target = TGT_VIA1;
				r.reg_index = {1'b0, base[12:9]};
			end else if (m >= 32'h2000 && m < 32'h4000) begin
				r.target = TGT_VIA2;
				r.reg_index = {1'b0, sub[12:9]};
			end else if (!wr && base >= 32'h8000 && base < 32'h8008) begin
				r.target = TGT_IMM;
				if (base[2:0] < 3'd6) begin
					r.data = mac_addr[8 * (5 - int'(base[2:0])) +: 8];
				end else if (base[2:0] == 3'd7) begin
					v = 8'hFF;
					for (int i = 0; i < 6; i++) begin
						v = v ^ mac_addr[8 * (5 - i) +: 8];
					end
					r.data = v;
				end else begin
					r.data = 8'h00;
				end
			end else if (base >= 32'hC000 && base < 32'hE000) begin
				r.target = TGT_SCC;
				r.lane = {base[2], base[1]};
			end else if (base >= 32'hE000 && base < 32'h1_0000) begin
				r.target = TGT_MEMC;
				r.reg_index = base[6:2];
				r.lane = base[1:0];
			end else if (base >= 32'h1_0000 && base < 32'h1_0100) begin
				r.target = TGT_SCSI;
				r.reg_index = {1'b0, base[7:4]};
			end else if (base >= 32'h1_0100 && base < 32'h1_0104) begin
				r.target = TGT_SDMA;
				r.lane = base[1:0];
				r.dma_timed = sub[19];
			end else if (m >= 32'h1_4000 && m < 32'h1_5000) begin
				r.target = TGT_SOUND;
				r.offset = 30'(addr[11:0]);
			end else if (m >= 32'h1_8000 && m < 32'h1_A000) begin
				r.target = TGT_IOREG;
				r.reg_index = sub[12:8];
				r.lane = {1'b0, sub[0]};
			end else if (m >= 32'h1_E000 && m < 32'h2_0000) begin
				if (!wr && addr[0]) begin
					r.target = TGT_IMM;
					r.data = 8'h00;
				end else begin
					r.target = TGT_FLOPPY;
					r.reg_index = {1'b0, sub[12:9]};
				end
			end else if (!wr) begin
				r.target = TGT_IMM;
			end
		end else if (addr >= 32'hF900_0000 && addr < 32'hF920_0000) begin
			r.target = TGT_VRAM;
			r.offset = 30'((addr - 32'hF900_0000) & (VRAM_SIZE - 1));
			r.data = pass;
		end else if (addr >= 32'hF980_0000 && addr < 32'hF980_0400) begin
			off = addr - 32'hF980_0000;
			if (wr && off[9:8] == 2'b11) begin
				r.target = TGT_CLKGEN;
				r.offset = off[29:0];
				r.lane = off[1:0];
				r.data = wb;
			end else if (!wr && off[9:2] == 8'h84 && off[1:0] != 2'b11) begin
				r.target = TGT_IMM;
			end else begin
				r.target = TGT_VIDEO;
				r.offset = off[29:0];
				r.lane = off[1:0];
				r.data = pass;
			end
		end else begin
			r.data = pass;
			r.bus_error = 1'b1;
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_decodes.size() == 0) begin
				$display("%0t: result with no access pending, target %0h", $time, target);
				errors++;
			end else begin
				want = pending_decodes.pop_front();
				check_field("target", 32'(want.target), 32'(target));
				check_field("offset", 32'(want.offset), 32'(offset));
				check_field("reg_index", 32'(want.reg_index), 32'(reg_index));
				check_field("lane", 32'(want.lane), 32'(lane));
				check_field("dma_timed", 32'(want.dma_timed), 32'(dma_timed));
				check_field("data", 32'(want.data), 32'(data));
				check_field("overlay_cleared", 32'(want.overlay_cleared),
					32'(overlay_cleared));
				check_field("bus_error", 32'(want.bus_error), 32'(bus_error));
			end
		end
	end

	// receiver: random stall bursts, or one long hold on request
	always begin
		@(negedge clk);
		if (long_hold) begin
			out_stall <= 1'b1;
			repeat (300) @(negedge clk);
			long_hold = 1'b0;
			out_stall <= 1'b0;
		end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 18)) @(negedge clk);
			out_stall <= 1'b0;
		end
	end

	task automatic send_access(input logic f, input logic [31:0] a, input logic [7:0] wb);
		@(negedge clk);
		if (tx_gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		address <= a;
		write_byte <= wb;
		do @(posedge clk); while (in_stall);
		pending_decodes.push_back(decode_access(f, a, wb));
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_decodes.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CfgDatW-1:0] value);
		logic [30:0] rounded;
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_RAM_BYTES: begin
				rounded = value[30:0];
				while ((rounded & (rounded - 31'd1)) != 0) rounded = rounded & (rounded - 31'd1);
				ram_size = rounded;
			end
			CFG_MACHINE_ID: id_word = value[31:0];
			CFG_NET_ADDR: mac_addr = value[47:0];
			default: ;
		endcase
	endtask

	function automatic logic [31:0] rand_address();
		logic [9:0]  hi;
		logic [17:0] base;
		logic [31:0] a;
		case ($urandom_range(0, 15))
			0, 1: a = $urandom;
			2: a = $urandom & 32'h3FFF_FFFF;
			3: a = $urandom & (32'(ram_size) - 32'd1) & 32'h3FFF_FFFF;
			4: a = 32'(ram_size) + $urandom_range(0, 7) - 32'd4;
			5: a = {4'h4, 28'($urandom)};
			6, 7, 8, 9: begin
				case ($urandom_range(0, 11))
					0: base = 18'($urandom_range(0, 32'h1FFF));
					1: base = 18'h2000 + 18'($urandom_range(0, 32'h1FFF));
					2: base = 18'h7FF8 + 18'($urandom_range(0, 23));
					3: base = 18'hC000 + 18'($urandom_range(0, 32'h1FFF));
					4: base = 18'hE000 + 18'($urandom_range(0, 32'h1FFF));
					5: base = 18'h1_0000 + 18'($urandom_range(0, 32'hFF));
					6: base = 18'h1_00FC + 18'($urandom_range(0, 15));
					7: base = 18'h1_4000 + 18'($urandom_range(0, 32'hFFF));
					8: base = 18'h1_8000 + 18'($urandom_range(0, 32'h1FFF));
					9: base = 18'h1_E000 + 18'($urandom_range(0, 32'h1FFF));
					default: base = 18'($urandom);
				endcase
				hi = '0;
				hi[5:2] = 4'($urandom);
				if ($urandom_range(0, 1) == 1) hi[1:0] = 2'($urandom);
				if ($urandom_range(0, 3) == 0) hi[9:6] = 4'($urandom);
				a = {4'h5, hi, base};
			end
			10: a = {16'h5FFF, 16'($urandom)};
			11: a = 32'hF900_0000 + $urandom_range(0, 32'h1F_FFFF);
			12: a = 32'hF980_0000 + $urandom_range(0, 32'h3FF);
			13: begin
				case ($urandom_range(0, 7))
					0: a = 32'h4000_0000;
					1: a = 32'h5000_0000;
					2: a = 32'h6000_0000;
					3: a = 32'hF900_0000;
					4: a = 32'hF920_0000;
					5: a = 32'hF980_0000;
					6: a = 32'hF980_0400;
					default: a = 32'h5FFF_0000;
				endcase
				a = a + $urandom_range(0, 3) - 32'd2;
			end
			14: a = {4'(6 + $urandom_range(0, 8)), 28'($urandom)};
			default: a = 32'hF920_0000 + $urandom_range(0, 32'h5F_FFFF);
		endcase
		return a;
	endfunction

	task automatic send_random(input int count);
		repeat (count) begin
			send_access(1'($urandom), rand_address(), 8'($urandom));
		end
	endtask

	task automatic test_boot_overlay();
		logic [31:0] a;
		logic        f;
		send_access(1'b0, 32'h0000_0000, 8'h00);
		send_access(1'b0, 32'h3FFF_FFFF, 8'h5A);
		send_access(1'b1, 32'h1234_5678, 8'hAA);
		send_access(1'b1, 32'h4ABC_DEF0, 8'h11);
		// ROM reads would end the overlay, so turn them into writes here
		repeat (100) begin
			a = rand_address();
			f = 1'($urandom);
			if (!f && a[31:28] == 4'h4) f = 1'b1;
			send_access(f, a, 8'($urandom));
		end
		send_access(1'b0, 32'h4FFF_FFFF, 8'h00);
		send_access(1'b0, 32'h4000_0000, 8'h00);
	endtask

	task automatic test_special_cases();
		send_access(1'b0, 32'h0000_0000, 8'h00);
		send_access(1'b1, 32'h007F_FFFF, 8'hFF);
		send_access(1'b0, 32'h0080_0000, 8'h00);
		send_access(1'b1, 32'h3FFF_FFFF, 8'h3C);
		send_access(1'b0, 32'h5FFF_0000, 8'h00);
		send_access(1'b0, 32'h5FFF_0003, 8'h00);
		send_access(1'b1, 32'h5FFF_FFFF, 8'h77);
		write_reg(CFG_NET_ADDR, 48'h8C3A_F102_5DE7);
		send_access(1'b0, 32'h5000_8000, 8'h00);
		send_access(1'b0, 32'h5000_8005, 8'h00);
		send_access(1'b0, 32'h5000_8006, 8'h00);
		send_access(1'b0, 32'h50F4_8007, 8'h00);
		send_access(1'b1, 32'h5000_8007, 8'h99);
		send_access(1'b0, 32'h5001_E001, 8'h00);
		send_access(1'b1, 32'h5001_E200, 8'h42);
		send_access(1'b0, 32'hF980_0210, 8'h00);
		send_access(1'b0, 32'hF980_0212, 8'h00);
		send_access(1'b0, 32'hF980_0213, 8'h00);
		send_access(1'b1, 32'hF980_03FF, 8'hC3);
		send_access(1'b0, 32'hF980_0300, 8'h00);
		send_access(1'b0, 32'h5000_6000, 8'h00);
		send_access(1'b1, 32'h5000_6000, 8'h24);
		send_access(1'b0, 32'hFFFF_FFFF, 8'h00);
		send_access(1'b1, 32'h6000_0000, 8'h81);
		send_access(1'b0, 32'h5009_0102, 8'h00);
		send_access(1'b1, 32'hF91F_FFFF, 8'h00);
	endtask

	task automatic test_config_sweep();
		logic [CfgDatW-1:0] ram_v, id_v, net_v;
		for (int s = 0; s < 6; s++) begin
			id_v = {16'($urandom), 32'($urandom)};
			net_v = {16'($urandom), 32'($urandom)};
			case (s)
				0: begin
					ram_v = '0;
					id_v = '0;
					net_v = '0;
				end
				1: begin
					ram_v = 48'h1;
					id_v = 48'hFFFF_FFFF;
					net_v = 48'hFFFF_FFFF_FFFF;
				end
				2: ram_v = 48'h4000_0000;
				3: ram_v = 48'h7FFF_FFFF;
				4: ram_v = {16'($urandom), 32'($urandom)};
				default: ram_v = 48'($urandom_range(32'h1_0000, 32'hFF_FFFF));
			endcase
			write_reg(CFG_RAM_BYTES, ram_v);
			write_reg(CFG_MACHINE_ID, id_v);
			write_reg(CFG_NET_ADDR, net_v);
			send_random(100);
		end
	endtask

	task automatic test_backpressure();
		rx_gaps = 1'b0;
		long_hold = 1'b1;
		send_random(60);
		drain();
		rx_gaps = 1'b1;
	endtask

	task automatic test_random_traffic();
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		send_random(500);
	endtask

	task automatic test_no_idle();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		send_random(150);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_boot_overlay();
		test_special_cases();
		test_config_sweep();
		test_backpressure();
		test_random_traffic();
		test_no_idle();
		drain();
		repeat (8) @(posedge clk);
		if (pending_decodes.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_decodes.size());
			errors++;
		end
		if (errors == 0) begin
			$display("tb_io_and_memory_address_decoder: PASS");
		end else begin
			$display("tb_io_and_memory_address_decoder: FAIL");
		end
		$finish;
	end

endmodule
